@@ src/c8cpu_pkg.sv @@
// c8cpu_pkg: shared constants, types and the hex font for the chip8 core
// used by the top, controller and datapath of the core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package c8cpu_pkg;

  localparam int C8_MEM_BYTES   = 4096;
  localparam int C8_AW          = $clog2(C8_MEM_BYTES);
  localparam int C8_STACK_DEPTH = 16;
  localparam int C8_SCREEN_W    = 64;
  localparam int C8_SCREEN_H    = 32;
  localparam int C8_FB_BYTES    = C8_SCREEN_W * C8_SCREEN_H / 8;
  localparam int C8_FBW         = $clog2(C8_FB_BYTES);
  localparam int C8_FONT_LEN    = 80;

  localparam logic [C8_AW-1:0] C8_PC_START  = 12'h200;
  localparam logic [C8_AW-1:0] C8_FONT_BASE = 12'h050;
  localparam logic [C8_AW-1:0] C8_FONT_END  = 12'h0A0;

  // command codes of the input channel
  localparam logic [2:0] CMD_EXEC  = 3'd0;
  localparam logic [2:0] CMD_MWR   = 3'd1;
  localparam logic [2:0] CMD_MRD   = 3'd2;
  localparam logic [2:0] CMD_KEY   = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_FRD   = 3'd5;

  // opcode groups and low-byte codes
  localparam logic [3:0] OPG_SYS   = 4'h0;
  localparam logic [3:0] OPG_JP    = 4'h1;
  localparam logic [3:0] OPG_CALL  = 4'h2;
  localparam logic [3:0] OPG_SEB   = 4'h3;
  localparam logic [3:0] OPG_SNEB  = 4'h4;
  localparam logic [3:0] OPG_SER   = 4'h5;
  localparam logic [3:0] OPG_LDB   = 4'h6;
  localparam logic [3:0] OPG_ADDB  = 4'h7;
  localparam logic [3:0] OPG_ALU   = 4'h8;
  localparam logic [3:0] OPG_SNER  = 4'h9;
  localparam logic [3:0] OPG_LDI   = 4'hA;
  localparam logic [3:0] OPG_JPV0  = 4'hB;
  localparam logic [3:0] OPG_RND   = 4'hC;
  localparam logic [3:0] OPG_DRW   = 4'hD;
  localparam logic [3:0] OPG_SKEY  = 4'hE;
  localparam logic [3:0] OPG_MISC  = 4'hF;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KK_CLS   = 8'hE0;
  localparam logic [7:0] KK_RET   = 8'hEE;
  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GDLY  = 8'h07;
  localparam logic [7:0] KK_WKEY  = 8'h0A;
  localparam logic [7:0] KK_SDLY  = 8'h15;
  localparam logic [7:0] KK_SSND  = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STR   = 8'h55;
  localparam logic [7:0] KK_LDR   = 8'h65;

  localparam logic [3:0] REG_VF = 4'hF;

  localparam logic [7:0] C8_FONT [C8_FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MWR, ST_MRD, ST_MRD2, ST_KEY, ST_TICK, ST_FRD, ST_FRD2,
    ST_F1, ST_F2, ST_F3, ST_RD, ST_EX, ST_RET, ST_VF,
    ST_DRD, ST_DFB, ST_DW0, ST_DW1, ST_BCD, ST_STA, ST_STB, ST_LDA, ST_LDB, ST_DONE
  } c8_state_t;

  // controller to datapath
  typedef struct packed {
    c8_state_t        st;
    logic [C8_AW-1:0] cnt;
    logic             accept;
    logic             out_load;
  } c8_cmd_t;

  // datapath to controller: decoded opcode fields
  typedef struct packed {
    logic [3:0] hi;
    logic [3:0] x;
    logic [3:0] n;
    logic [7:0] kk;
  } c8_stat_t;

endpackage

`default_nettype wire

@@ src/c8cpu_if.sv @@
// c8cpu_in_if / c8cpu_out_if: valid/ready channels of the chip8 core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface c8cpu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [11:0] addr;
  logic [7:0]  wdata;
  logic [3:0]  key_index;
  logic        key_down;
  logic [7:0]  rand_byte;
  modport source (output valid, cmd, addr, wdata, key_index, key_down, rand_byte,
                  input ready);
  modport sink (input valid, cmd, addr, wdata, key_index, key_down, rand_byte,
                output ready);
endinterface

interface c8cpu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [11:0] pc_now;
  logic        draw;
  logic        sound_on;
  logic        waiting_key;
  logic        stack_fault;
  modport source (output valid, read_data, pc_now, draw, sound_on, waiting_key,
                  stack_fault, input ready);
  modport sink (input valid, read_data, pc_now, draw, sound_on, waiting_key,
                stack_fault, output ready);
endinterface

`default_nettype wire

@@ src/chip8_cpu_core_top.sv @@
// chip8_cpu_core_top: chip8 processor core, controller plus datapath
// depends on c8cpu_pkg, c8cpu_if, c8cpu_ctrl, c8cpu_dp
//
//   channel    dir   handshake      payload
//   in_port    in    valid/ready    cmd, addr, wdata, key_index, key_down, rand_byte
//   out_port   out   valid/ready    read_data, pc_now, draw, sound_on, waiting_key,
//                                   stack_fault
//
// one command at a time; memory, register file and frame buffer each have one
// write port with registered reads; an unknown command goes straight to the
// result, an instruction is fetched, its registers read, then executed; a
// flag-writing alu op or return adds a step, FX33 writes three digits, a sprite
// draw works row by row on frame bytes, FX55/FX65 register by register
// after reset a pass over all 4096 bytes loads memory with zero and the font;
// no command is taken until it ends
// a finished result waits in the output register; the next command is taken
// meanwhile, and only its own result waits for the slot to free
`timescale 1ns / 1ps
`default_nettype none

module chip8_cpu_core_top import c8cpu_pkg::*; #(
  parameter int STACK_DEPTH = C8_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  c8cpu_in_if.sink   in_port,
  c8cpu_out_if.source out_port
);

  c8_cmd_t  cmd;
  c8_stat_t stat;

  c8cpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_cmd    (in_port.cmd),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  c8cpu_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_addr         (in_port.addr),
    .in_wdata        (in_port.wdata),
    .in_key_index    (in_port.key_index),
    .in_key_down     (in_port.key_down),
    .in_rand_byte    (in_port.rand_byte),
    .out_read_data   (out_port.read_data),
    .out_pc_now      (out_port.pc_now),
    .out_draw        (out_port.draw),
    .out_sound_on    (out_port.sound_on),
    .out_waiting_key (out_port.waiting_key),
    .out_stack_fault (out_port.stack_fault)
  );

endmodule

`default_nettype wire

@@ src/c8cpu_ctrl.sv @@
// c8cpu_ctrl: sequencer state machine of the chip8 core
// depends on c8cpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module c8cpu_ctrl import c8cpu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  c8_stat_t   stat_i,
  output c8_cmd_t    cmd_o
);

  c8_state_t        state_r, state_nxt;
  logic [C8_AW-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == C8_AW'(C8_MEM_BYTES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          case (in_cmd)
            CMD_EXEC: state_nxt = ST_F1;
            CMD_MWR:  state_nxt = ST_MWR;
            CMD_MRD:  state_nxt = ST_MRD;
            CMD_KEY:  state_nxt = ST_KEY;
            CMD_TICK: state_nxt = ST_TICK;
            CMD_FRD:  state_nxt = ST_FRD;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MWR, ST_KEY, ST_TICK, ST_MRD2, ST_FRD2, ST_RET, ST_VF: state_nxt = ST_DONE;
      ST_MRD:  state_nxt = ST_MRD2;
      ST_FRD:  state_nxt = ST_FRD2;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EX;
      ST_EX: begin
        cnt_nxt   = '0;
        state_nxt = ST_DONE;
        if (stat_i.hi == OPG_SYS && stat_i.x == 4'h0 && stat_i.kk == KK_RET) begin
          state_nxt = ST_RET;
        end else if (stat_i.hi == OPG_ALU &&
                     (stat_i.n == ALU_ADD || stat_i.n == ALU_SUB || stat_i.n == ALU_SHR ||
                      stat_i.n == ALU_SUBN || stat_i.n == ALU_SHL)) begin
          state_nxt = ST_VF;
        end else if (stat_i.hi == OPG_DRW) begin
          state_nxt = (stat_i.n == 4'h0) ? ST_VF : ST_DRD;
        end else if (stat_i.hi == OPG_MISC) begin
          if (stat_i.kk == KK_BCD) state_nxt = ST_BCD;
          else if (stat_i.kk == KK_STR) state_nxt = ST_STA;
          else if (stat_i.kk == KK_LDR) state_nxt = ST_LDA;
        end
      end
      // sprite rows: fetch, read two frame bytes, write them back
      ST_DRD: state_nxt = ST_DFB;
      ST_DFB: state_nxt = ST_DW0;
      ST_DW0: state_nxt = ST_DW1;
      ST_DW1: begin
        if (cnt_r[3:0] + 4'd1 == stat_i.n) begin
          state_nxt = ST_VF;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_DRD;
        end
      end
      ST_BCD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd2) state_nxt = ST_DONE;
      end
      ST_STA: state_nxt = ST_STB;
      ST_STB: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == stat_i.x) ? ST_DONE : ST_STA;
      end
      ST_LDA: state_nxt = ST_LDB;
      ST_LDB: begin
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_r[3:0] == stat_i.x) ? ST_DONE : ST_LDA;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cmd_o = '{st: state_r, cnt: cnt_r, accept: accept, out_load: out_load};

endmodule

`default_nettype wire

@@ src/c8cpu_dp.sv @@
// c8cpu_dp: datapath of the chip8 core with memory, registers, stack, frame
// depends on c8cpu_pkg; driven by c8cpu_ctrl
`timescale 1ns / 1ps
`default_nettype none

module c8cpu_dp import c8cpu_pkg::*; #(
  parameter int STACK_DEPTH = C8_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  c8_cmd_t     cmd_i,
  output c8_stat_t    stat_o,
  input  logic [11:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [3:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [7:0]  in_rand_byte,
  output logic [7:0]  out_read_data,
  output logic [11:0] out_pc_now,
  output logic        out_draw,
  output logic        out_sound_on,
  output logic        out_waiting_key,
  output logic        out_stack_fault
);

  localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  c8_state_t st;
  logic [C8_AW-1:0] cnt;
  assign st  = cmd_i.st;
  assign cnt = cmd_i.cnt;

  // latched transaction fields
  logic [11:0] addr_r;
  logic [7:0]  wdata_r, rnd_r;
  logic [3:0]  key_r;
  logic        down_r;

  // architectural state
  logic [7:0]       op_hi_r, op_lo_r;
  logic [C8_AW-1:0] pc_r;
  logic [15:0]      idx_r;
  logic [SPW-1:0]   sp_r;
  logic [7:0]       dly_r, snd_r;
  logic [15:0]      keys_r;
  logic [7:0]       rd_r;
  logic             draw_r, wait_r, fault_r, flag_r;

  // stores
  logic [7:0]  mem [C8_MEM_BYTES];
  logic [7:0]  mem_q;
  logic [7:0]  regs [16];
  logic [15:0] regs_v;
  logic [7:0]  rq_a, rq_b;
  logic [C8_AW-1:0] stk [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] stk_v;
  logic [C8_AW-1:0] stk_q;
  logic [7:0]  fb [C8_FB_BYTES];
  logic [C8_FB_BYTES-1:0] fb_v;
  logic [7:0]  fb_qa, fb_qb;

  // sprite row staging
  logic [7:0]      pa_r, pb_r, wb_r;
  logic [C8_FBW-1:0] ba_r, bb_r;

  // decode
  logic [3:0] hi, x, y, n;
  logic [7:0] kk, vx, vy;
  logic [C8_AW-1:0] nnn;
  assign hi  = op_hi_r[7:4];
  assign x   = op_hi_r[3:0];
  assign y   = op_lo_r[7:4];
  assign n   = op_lo_r[3:0];
  assign kk  = op_lo_r;
  assign nnn = {op_hi_r[3:0], op_lo_r};
  assign vx  = rq_a;
  assign vy  = rq_b;
  assign stat_o = '{hi: hi, x: x, n: n, kk: kk};

  logic [C8_AW-1:0] pc_p2, pc_p4, ex_pc, mem_row;
  assign pc_p2   = pc_r + 12'd2;
  assign pc_p4   = pc_r + 12'd4;
  assign mem_row = idx_r[C8_AW-1:0] + cnt;

  // stack pointer wrap
  logic [SPW-1:0] sp_inc, sp_dec;
  assign sp_inc = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;

  // keys: skip test and lowest pressed key
  logic       key_hit, key_any;
  logic [3:0] key_enc;
  assign key_hit = keys_r[vx[3:0]];
  assign key_any = |keys_r;
  always_comb begin
    key_enc = 4'h0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_r[i]) key_enc = 4'(i);
    end
  end

  // decimal digits of vx
  logic        h1, h2;
  logic [7:0]  rem, d_hund, d_tens, d_ones, bcd_d;
  logic [14:0] tprod;
  assign h2     = (vx >= 8'd200);
  assign h1     = (vx >= 8'd100);
  assign d_hund = h2 ? 8'd2 : (h1 ? 8'd1 : 8'd0);
  assign rem    = vx - (h2 ? 8'd200 : (h1 ? 8'd100 : 8'd0));
  assign tprod  = 15'(rem[6:0]) * 15'd205;
  assign d_tens = {4'h0, tprod[14:11]};
  assign d_ones = rem - 8'(d_tens * 8'd10);
  always_comb begin
    case (cnt[1:0])
      2'd0:    bcd_d = d_hund;
      2'd1:    bcd_d = d_tens;
      default: bcd_d = d_ones;
    endcase
  end

  // sprite placement for the current row
  logic [4:0]  py;
  logic [5:0]  px;
  logic [15:0] spr16;
  logic [C8_FBW-1:0] ba, bb;
  assign py    = vy[4:0] + cnt[4:0];
  assign px    = vx[5:0];
  assign spr16 = {mem_q, 8'h00} >> px[2:0];
  assign ba    = {py, px[5:3]};
  assign bb    = {py, px[5:3] + 3'd1};

  // register write of the execute step
  logic       ex_rwe, ex_flag;
  logic [7:0] ex_rwd;
  logic [8:0] add9;
  assign add9 = {1'b0, vx} + {1'b0, vy};
  always_comb begin
    ex_rwe  = 1'b0;
    ex_rwd  = 8'h00;
    ex_flag = 1'b0;
    case (hi)
      OPG_LDB:  begin ex_rwe = 1'b1; ex_rwd = kk; end
      OPG_ADDB: begin ex_rwe = 1'b1; ex_rwd = vx + kk; end
      OPG_RND:  begin ex_rwe = 1'b1; ex_rwd = rnd_r & kk; end
      OPG_ALU: begin
        case (n)
          ALU_MOV:  begin ex_rwe = 1'b1; ex_rwd = vy; end
          ALU_OR:   begin ex_rwe = 1'b1; ex_rwd = vx | vy; end
          ALU_AND:  begin ex_rwe = 1'b1; ex_rwd = vx & vy; end
          ALU_XOR:  begin ex_rwe = 1'b1; ex_rwd = vx ^ vy; end
          ALU_ADD:  begin ex_rwe = 1'b1; ex_rwd = add9[7:0]; ex_flag = add9[8]; end
          ALU_SUB:  begin ex_rwe = 1'b1; ex_rwd = vx - vy; ex_flag = (vx >= vy); end
          ALU_SHR:  begin ex_rwe = 1'b1; ex_rwd = {1'b0, vx[7:1]}; ex_flag = vx[0]; end
          ALU_SUBN: begin ex_rwe = 1'b1; ex_rwd = vy - vx; ex_flag = (vy >= vx); end
          ALU_SHL:  begin ex_rwe = 1'b1; ex_rwd = {vx[6:0], 1'b0}; ex_flag = vx[7]; end
          default: ;
        endcase
      end
      OPG_MISC: begin
        if (kk == KK_GDLY) begin
          ex_rwe = 1'b1; ex_rwd = dly_r;
        end else if (kk == KK_WKEY && key_any) begin
          ex_rwe = 1'b1; ex_rwd = {4'h0, key_enc};
        end
      end
      default: ;
    endcase
  end

  // next pc of the execute step
  always_comb begin
    ex_pc = pc_p2;
    case (hi)
      OPG_JP, OPG_CALL: ex_pc = nnn;
      OPG_SEB:  if (vx == kk) ex_pc = pc_p4;
      OPG_SNEB: if (vx != kk) ex_pc = pc_p4;
      OPG_SER:  if (n == 4'h0 && vx == vy) ex_pc = pc_p4;
      OPG_SNER: if (n == 4'h0 && vx != vy) ex_pc = pc_p4;
      OPG_JPV0: ex_pc = nnn + {4'h0, vx};
      OPG_SKEY: begin
        if ((kk == KK_SKP && key_hit) || (kk == KK_SKNP && !key_hit)) ex_pc = pc_p4;
      end
      OPG_MISC: if (kk == KK_WKEY && !key_any) ex_pc = pc_r;
      default: ;
    endcase
  end

  // main memory port selection
  logic             mem_we;
  logic [C8_AW-1:0] mem_wa, mem_ra;
  logic [7:0]       mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = mem_row;
    mem_wd = rq_a;
    mem_ra = mem_row;
    case (st)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt;
        mem_wd = (cnt >= C8_FONT_BASE && cnt < C8_FONT_END) ?
                 C8_FONT[7'(cnt - C8_FONT_BASE)] : 8'h00;
      end
      ST_MWR: begin mem_we = 1'b1; mem_wa = addr_r; mem_wd = wdata_r; end
      ST_BCD: begin mem_we = 1'b1; mem_wd = bcd_d; end
      ST_STB: mem_we = 1'b1;
      ST_MRD: mem_ra = addr_r;
      ST_F1:  mem_ra = pc_r;
      ST_F2:  mem_ra = pc_r + 12'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // register file ports
  logic       rg_we, re_a;
  logic [3:0] rg_wa, ra_a;
  logic [7:0] rg_wd;
  always_comb begin
    rg_we = 1'b0;
    rg_wa = x;
    rg_wd = ex_rwd;
    case (st)
      ST_EX:  rg_we = ex_rwe;
      ST_VF:  begin rg_we = 1'b1; rg_wa = REG_VF; rg_wd = {7'h00, flag_r}; end
      ST_LDB: begin rg_we = 1'b1; rg_wa = cnt[3:0]; rg_wd = mem_q; end
      default: ;
    endcase
  end
  assign re_a = (st == ST_RD) || (st == ST_STA);
  assign ra_a = (st == ST_STA) ? cnt[3:0] : ((hi == OPG_JPV0) ? 4'h0 : x);

  always_ff @(posedge clk) begin
    if (rg_we) regs[rg_wa] <= rg_wd;
    if (re_a) rq_a <= regs_v[ra_a] ? regs[ra_a] : 8'h00;
    if (st == ST_RD) rq_b <= regs_v[y] ? regs[y] : 8'h00;
  end

  // call stack
  always_ff @(posedge clk) begin
    if (st == ST_EX && hi == OPG_CALL) stk[sp_r] <= pc_p2;
    stk_q <= stk_v[sp_dec] ? stk[sp_dec] : '0;
  end

  // frame buffer, eight pixels a byte
  logic              fb_we;
  logic [C8_FBW-1:0] fb_wa, fb_ra;
  logic [7:0]        fb_wd;
  assign fb_we = (st == ST_DW0) || (st == ST_DW1);
  assign fb_wa = (st == ST_DW0) ? ba_r : bb_r;
  assign fb_wd = (st == ST_DW0) ? (fb_qa ^ pa_r) : wb_r;
  assign fb_ra = (st == ST_FRD) ? addr_r[C8_FBW-1:0] : ba;

  always_ff @(posedge clk) begin
    if (fb_we) fb[fb_wa] <= fb_wd;
    fb_qa <= fb_v[fb_ra] ? fb[fb_ra] : 8'h00;
    fb_qb <= fb_v[bb] ? fb[bb] : 8'h00;
  end

  // transaction fields, fetched opcode and sprite staging
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      addr_r  <= in_addr;
      wdata_r <= in_wdata;
      key_r   <= in_key_index;
      down_r  <= in_key_down;
      rnd_r   <= in_rand_byte;
    end
    if (st == ST_F2) op_hi_r <= mem_q;
    if (st == ST_F3) op_lo_r <= mem_q;
    if (st == ST_DFB) begin
      pa_r <= spr16[15:8];
      pb_r <= spr16[7:0];
      ba_r <= ba;
      bb_r <= bb;
    end
    if (st == ST_DW0) wb_r <= fb_qb ^ pb_r;
  end

  // processor state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= C8_PC_START;
      idx_r   <= '0;
      sp_r    <= '0;
      dly_r   <= '0;
      snd_r   <= '0;
      keys_r  <= '0;
      regs_v  <= '0;
      stk_v   <= '0;
      fb_v    <= '0;
      rd_r    <= '0;
      draw_r  <= 1'b0;
      wait_r  <= 1'b0;
      fault_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rd_r    <= '0;
        draw_r  <= 1'b0;
        wait_r  <= 1'b0;
        fault_r <= 1'b0;
      end
      if (rg_we) regs_v[rg_wa] <= 1'b1;
      case (st)
        ST_KEY:  keys_r[key_r] <= down_r;
        ST_TICK: begin
          if (dly_r != 8'h00) dly_r <= dly_r - 8'd1;
          if (snd_r != 8'h00) snd_r <= snd_r - 8'd1;
        end
        ST_MRD2: rd_r <= mem_q;
        ST_FRD2: rd_r <= fb_qa;
        ST_EX: begin
          pc_r   <= ex_pc;
          flag_r <= ex_flag;
          case (hi)
            OPG_SYS: begin
              if (x == 4'h0 && kk == KK_CLS) begin
                fb_v   <= '0;
                draw_r <= 1'b1;
              end else if (x == 4'h0 && kk == KK_RET) begin
                fault_r <= (sp_r == '0);
                sp_r    <= sp_dec;
              end
            end
            OPG_CALL: begin
              stk_v[sp_r] <= 1'b1;
              sp_r        <= sp_inc;
              fault_r     <= (sp_inc == '0);
            end
            OPG_LDI: idx_r  <= {4'h0, nnn};
            OPG_DRW: draw_r <= 1'b1;
            OPG_MISC: begin
              case (kk)
                KK_WKEY: wait_r <= !key_any;
                KK_SDLY: dly_r  <= vx;
                KK_SSND: snd_r  <= vx;
                KK_ADDI: idx_r  <= idx_r + {8'h00, vx};
                KK_FONT: idx_r  <= {4'h0, C8_FONT_BASE} + {6'h00, vx, 2'b00}
                                   + {8'h00, vx};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        ST_RET: pc_r <= stk_q;
        ST_DW0: begin
          flag_r      <= flag_r | (|(fb_qa & pa_r)) | (|(fb_qb & pb_r));
          fb_v[ba_r]  <= 1'b1;
        end
        ST_DW1: fb_v[bb_r] <= 1'b1;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_read_data   <= rd_r;
      out_pc_now      <= pc_r;
      out_draw        <= draw_r;
      out_sound_on    <= (snd_r != 8'h00);
      out_waiting_key <= wait_r;
      out_stack_fault <= fault_r;
    end
  end

endmodule

`default_nettype wire

@@ src/c8cpu_chk.sv @@
// c8cpu_chk: port-level checks of the chip8 core, bound to the top level
// depends on chip8_cpu_core_top
`timescale 1ns / 1ps
`default_nettype none

module c8cpu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [11:0] out_pc_now,
  input logic        out_draw,
  input logic        out_waiting_key,
  input logic        out_stack_fault
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc_now) && $stable(out_read_data))
    else $error("result changed while stalled");

  // one command in flight: ready drops after a transaction
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  // no command taken right after reset, when the memory load pass starts
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready right after reset");

  // key wait comes only from FX0A, which neither draws nor touches the stack
  a_wait_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_waiting_key |-> !out_draw && !out_stack_fault && out_read_data == 8'h00)
    else $error("key wait mixed with other status");

endmodule

bind chip8_cpu_core_top c8cpu_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_port.valid),
  .in_ready        (in_port.ready),
  .out_valid       (out_port.valid),
  .out_ready       (out_port.ready),
  .out_read_data   (out_port.read_data),
  .out_pc_now      (out_port.pc_now),
  .out_draw        (out_port.draw),
  .out_waiting_key (out_port.waiting_key),
  .out_stack_fault (out_port.stack_fault)
);

`default_nettype wire
